@@ rtl/assert_macros.svh @@
// Assertion macros shared by the order book RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LOBM_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be true outside reset.
`define LOBM_NEVER(name, clk, rstn, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

@@ rtl/lobm_pkg.sv @@
// Shared types, constants and helper functions for the order book.
`default_nettype none

package lobm_pkg;

    localparam int PRICE_LEVELS_DEF     = 1024;
    localparam int ORDERS_PER_LEVEL_DEF = 16;

    localparam int PRICE_W   = 10;
    localparam int QTY_W     = 24;
    localparam int ID_W      = 32;
    localparam int FILLS_W   = 16;
    localparam int ENTRY_W   = ID_W + QTY_W;
    localparam int OCC_BITS  = 64;
    localparam int OCC_BIT_W = 6;
    localparam int LVL_EXT_W = 17;

    localparam logic OP_MATCH  = 1'b0;
    localparam logic OP_REST   = 1'b1;
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic in_ready;
        logic clr;
        logic lvl_rd_match;
        logic ent_rd;
        logic match_upd;
        logic scan_init;
        logic scan_rd;
        logic scan_eval;
        logic rest_rd;
        logic rest_upd;
        logic out_load;
    } lobm_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_fire;
        logic qty_zero;
        logic match_op;
        logic rem_zero;
        logic crosses;
        logic pops;
        logic empties;
        logic scan_hit;
        logic scan_last;
        logic clear_done;
        logic out_free;
    } lobm_stat_t;

    // Index of the highest set bit of an occupancy word
    function automatic logic [OCC_BIT_W-1:0] occ_hi(input logic [OCC_BITS-1:0] w);
        logic [OCC_BIT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < OCC_BITS; i++) begin
            if (w[i]) idx = OCC_BIT_W'(i);
        end
        return idx;
    endfunction

    // Index of the lowest set bit of an occupancy word
    function automatic logic [OCC_BIT_W-1:0] occ_lo(input logic [OCC_BITS-1:0] w);
        logic [OCC_BIT_W-1:0] idx;
        idx = '0;
        for (int i = OCC_BITS - 1; i >= 0; i--) begin
            if (w[i]) idx = OCC_BIT_W'(i);
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ rtl/lobm_in_if.sv @@
// Order input channel: valid/ready handshake with the order fields.
`default_nettype none

interface lobm_in_if import lobm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
    logic [ID_W-1:0]    order_id;

    modport source (output valid, opcode, side, price, quantity, order_id, input ready);
    modport sink   (input valid, opcode, side, price, quantity, order_id, output ready);
endinterface

`default_nettype wire

@@ rtl/lobm_out_if.sv @@
// Result output channel: valid/ready handshake with the summary fields.
`default_nettype none

interface lobm_out_if import lobm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [QTY_W-1:0]   filled_quantity;
    logic [QTY_W-1:0]   remaining_quantity;
    logic               rested;
    logic               rejected;
    logic [FILLS_W-1:0] fill_count;
    logic               best_bid_valid;
    logic [PRICE_W-1:0] best_bid_price;
    logic               best_ask_valid;
    logic [PRICE_W-1:0] best_ask_price;

    modport source (output valid, filled_quantity, remaining_quantity, rested, rejected,
                    fill_count, best_bid_valid, best_bid_price, best_ask_valid,
                    best_ask_price, input ready);
    modport sink   (input valid, filled_quantity, remaining_quantity, rested, rejected,
                    fill_count, best_bid_valid, best_bid_price, best_ask_valid,
                    best_ask_price, output ready);
endinterface

`default_nettype wire

@@ rtl/lobm_ctrl.sv @@
// Order book controller: sequences clearing, matching, scanning and resting.
`default_nettype none
`include "assert_macros.svh"

module lobm_ctrl import lobm_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  lobm_stat_t stat,
    output lobm_cmd_t  cmd
);

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b00_0000_0001,
        ST_IDLE  = 10'b00_0000_0010,
        ST_MCHK  = 10'b00_0000_0100,
        ST_MLVL  = 10'b00_0000_1000,
        ST_MENT  = 10'b00_0001_0000,
        ST_SREAD = 10'b00_0010_0000,
        ST_SEVAL = 10'b00_0100_0000,
        ST_RREAD = 10'b00_1000_0000,
        ST_RUPD  = 10'b01_0000_0000,
        ST_DONE  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clear_done) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_fire)
                begin
                    priority if (stat.qty_zero) state_next = ST_DONE;
                    else if (stat.match_op)     state_next = ST_MCHK;
                    else                        state_next = ST_RREAD;
                end
            end
            ST_MCHK:
            begin
                priority if (!stat.rem_zero && stat.crosses)
                begin
                    cmd.lvl_rd_match = 1'b1;
                    state_next       = ST_MLVL;
                end
                else if (stat.rem_zero) state_next = ST_DONE;
                else                    state_next = ST_RREAD;
            end
            ST_MLVL:
            begin
                cmd.ent_rd = 1'b1;
                state_next = ST_MENT;
            end
            ST_MENT:
            begin
                cmd.match_upd = 1'b1;
                if (stat.pops && stat.empties)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SREAD;
                end
                else
                begin
                    state_next = ST_MCHK;
                end
            end
            ST_SREAD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SEVAL;
            end
            ST_SEVAL:
            begin
                cmd.scan_eval = 1'b1;
                if (stat.scan_hit || stat.scan_last) state_next = ST_MCHK;
                else                                 state_next = ST_SREAD;
            end
            ST_RREAD:
            begin
                cmd.rest_rd = 1'b1;
                state_next  = ST_RUPD;
            end
            ST_RUPD:
            begin
                cmd.rest_upd = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // A scan read follows either the start of a scan or an empty word
    `LOBM_ASSERT(a_scan_order, clk, rst_n, (state_reg == ST_SREAD) |-> ($past(state_reg) == ST_MENT || $past(state_reg) == ST_SEVAL), "scan read out of sequence")
    `LOBM_NEVER(a_load_blocked, clk, rst_n, cmd.out_load && !stat.out_free, "result loaded over a waiting item")
    // Exactly one state bit is set
    `LOBM_ASSERT(a_state_onehot, clk, rst_n, $onehot(state_reg), "state register not one-hot")

endmodule

`default_nettype wire

@@ rtl/lobm_dp.sv @@
// Order book datapath: order registers, book memories, best levels, result register.
`default_nettype none
`include "assert_macros.svh"

module lobm_dp import lobm_pkg::*;
#(
    parameter int PRICE_LEVELS     = PRICE_LEVELS_DEF,
    parameter int ORDERS_PER_LEVEL = ORDERS_PER_LEVEL_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,
    lobm_in_if.sink     orders,
    lobm_out_if.source  results,
    input  lobm_cmd_t   cmd,
    output lobm_stat_t  stat
);

    localparam int LW        = $clog2(PRICE_LEVELS);
    localparam int HW        = (ORDERS_PER_LEVEL > 1) ? $clog2(ORDERS_PER_LEVEL) : 1;
    localparam int CW        = $clog2(ORDERS_PER_LEVEL + 1);
    localparam int OCC_WORDS = (PRICE_LEVELS + OCC_BITS - 1) / OCC_BITS;
    localparam int OWW       = (OCC_WORDS > 1) ? $clog2(OCC_WORDS) : 1;
    localparam int LA_W      = LW + 1;
    localparam int EA_W      = 1 + LW + HW;
    localparam int OA_W      = OWW + 1;
    localparam int LD_W      = HW + CW;

    // Order and book registers
    logic                 side_reg, side_next;
    logic [LW-1:0]        price_reg, price_next;
    logic [QTY_W-1:0]     rem_reg, rem_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [QTY_W-1:0]     filled_reg, filled_next;
    logic [FILLS_W-1:0]   touches_reg, touches_next;
    logic                 rested_reg, rested_next;
    logic                 rejected_reg, rejected_next;
    logic                 bbv_reg, bbv_next;
    logic [LW-1:0]        bbl_reg, bbl_next;
    logic                 bav_reg, bav_next;
    logic [LW-1:0]        bal_reg, bal_next;
    logic [OWW-1:0]       scan_word_reg, scan_word_next;
    logic [LW:0]          clr_cnt_reg, clr_cnt_next;

    // Result register
    logic                 out_valid_reg, out_valid_next;
    logic [QTY_W-1:0]     out_filled_reg, out_rem_reg;
    logic                 out_rested_reg, out_rejected_reg;
    logic [FILLS_W-1:0]   out_fills_reg;
    logic                 out_bbv_reg, out_bav_reg;
    logic [PRICE_W-1:0]   out_bbp_reg, out_bap_reg;

    // Memories
    logic [LD_W-1:0]      lvl_mem [0:(1 << LA_W) - 1];
    logic [ENTRY_W-1:0]   ent_mem [0:(1 << EA_W) - 1];
    logic [OCC_BITS-1:0]  occ_mem [0:(1 << OA_W) - 1];
    logic [LD_W-1:0]      lvl_rd_reg;
    logic [ENTRY_W-1:0]   ent_rd_reg;
    logic [OCC_BITS-1:0]  occ_rd_reg;

    logic                 lvl_re, lvl_we, ent_re, ent_we, occ_re, occ_we;
    logic [LA_W-1:0]      lvl_ra, lvl_wa;
    logic [LD_W-1:0]      lvl_wd;
    logic [EA_W-1:0]      ent_ra, ent_wa;
    logic [ENTRY_W-1:0]   ent_wd;
    logic [OA_W-1:0]      occ_ra, occ_wa;
    logic [OCC_BITS-1:0]  occ_wd;

    // Derived values
    logic                 opp;
    logic                 opp_valid;
    logic [LW-1:0]        opp_lvl;
    logic [LW-1:0]        price_sat;
    logic [LVL_EXT_W-1:0] opp_ext, price_ext;
    logic [OWW-1:0]       opp_word, price_word;
    logic [OCC_BITS-1:0]  opp_mask, price_mask;
    logic [HW-1:0]        head;
    logic [CW-1:0]        count;
    logic [HW:0]          head_inc;
    logic [HW-1:0]        head_wrap;
    logic [CW:0]          tail_sum;
    logic [HW-1:0]        tail;
    logic                 room;
    logic [QTY_W-1:0]     rq, trade;
    logic                 pops;
    logic [OCC_BIT_W-1:0] scan_bit;
    logic [LW-1:0]        scan_lvl;
    logic                 scan_hit, scan_last;

    assign price_sat = (LVL_EXT_W'(orders.price) >= LVL_EXT_W'(PRICE_LEVELS))
                       ? LW'(PRICE_LEVELS - 1) : LW'(orders.price);

    // Opposite side of the working order and its best level
    assign opp       = ~side_reg;
    assign opp_valid = (side_reg == SIDE_BUY) ? bav_reg : bbv_reg;
    assign opp_lvl   = (side_reg == SIDE_BUY) ? bal_reg : bbl_reg;
    assign opp_ext   = LVL_EXT_W'(opp_lvl);
    assign price_ext = LVL_EXT_W'(price_reg);
    assign opp_word  = OWW'(opp_ext[LVL_EXT_W-1:OCC_BIT_W]);
    assign price_word = OWW'(price_ext[LVL_EXT_W-1:OCC_BIT_W]);
    assign opp_mask  = OCC_BITS'(1) << opp_ext[OCC_BIT_W-1:0];
    assign price_mask = OCC_BITS'(1) << price_ext[OCC_BIT_W-1:0];

    // Level FIFO pointers
    assign head      = lvl_rd_reg[LD_W-1:CW];
    assign count     = lvl_rd_reg[CW-1:0];
    assign head_inc  = (HW + 1)'(head) + (HW + 1)'(1);
    assign head_wrap = (head_inc >= (HW + 1)'(ORDERS_PER_LEVEL)) ? '0 : HW'(head_inc);
    assign tail_sum  = (CW + 1)'(head) + (CW + 1)'(count);
    assign tail      = (tail_sum >= (CW + 1)'(ORDERS_PER_LEVEL))
                       ? HW'(tail_sum - (CW + 1)'(ORDERS_PER_LEVEL)) : HW'(tail_sum);
    assign room      = count < CW'(ORDERS_PER_LEVEL);

    // One trade step
    assign rq    = ent_rd_reg[QTY_W-1:0];
    assign pops  = rq <= rem_reg;
    assign trade = pops ? rq : rem_reg;

    // Occupancy scan of one word
    assign scan_bit  = (opp == SIDE_SELL) ? occ_lo(occ_rd_reg) : occ_hi(occ_rd_reg);
    assign scan_lvl  = LW'({(LVL_EXT_W - OCC_BIT_W)'(scan_word_reg), scan_bit});
    assign scan_hit  = |occ_rd_reg;
    assign scan_last = (opp == SIDE_SELL) ? (scan_word_reg == OWW'(OCC_WORDS - 1))
                                          : (scan_word_reg == '0);

    // Status
    always_comb
    begin
        stat.in_fire    = orders.valid && orders.ready;
        stat.qty_zero   = orders.quantity == '0;
        stat.match_op   = orders.opcode == OP_MATCH;
        stat.rem_zero   = rem_reg == '0;
        stat.crosses    = opp_valid && ((side_reg == SIDE_BUY) ? (price_reg >= opp_lvl)
                                                               : (price_reg <= opp_lvl));
        stat.pops       = pops;
        stat.empties    = count == CW'(1);
        stat.scan_hit   = scan_hit;
        stat.scan_last  = scan_last;
        stat.clear_done = &clr_cnt_reg;
        stat.out_free   = !out_valid_reg || results.ready;
    end

    assign orders.ready = cmd.in_ready;

    // Memory port selection
    always_comb
    begin
        lvl_re = cmd.lvl_rd_match || cmd.rest_rd;
        lvl_ra = cmd.lvl_rd_match ? {opp, opp_lvl} : {side_reg, price_reg};
        ent_re = cmd.ent_rd;
        ent_ra = {opp, opp_lvl, head};
        occ_re = cmd.lvl_rd_match || cmd.scan_rd || cmd.rest_rd;
        priority if (cmd.lvl_rd_match) occ_ra = {opp, opp_word};
        else if (cmd.scan_rd)          occ_ra = {opp, scan_word_reg};
        else                           occ_ra = {side_reg, price_word};

        lvl_we = 1'b0;
        lvl_wa = {opp, opp_lvl};
        lvl_wd = '0;
        ent_we = 1'b0;
        ent_wa = {opp, opp_lvl, head};
        ent_wd = {ent_rd_reg[ENTRY_W-1:QTY_W], rq - trade};
        occ_we = 1'b0;
        occ_wa = {opp, opp_word};
        occ_wd = occ_rd_reg & ~opp_mask;
        priority if (cmd.clr)
        begin
            lvl_we = 1'b1;
            lvl_wa = clr_cnt_reg;
            occ_we = 1'b1;
            occ_wa = clr_cnt_reg[OWW:0];
            occ_wd = '0;
        end
        else if (cmd.match_upd)
        begin
            if (pops)
            begin
                lvl_we = 1'b1;
                lvl_wd = {head_wrap, count - CW'(1)};
                occ_we = count == CW'(1);
            end
            else
            begin
                ent_we = 1'b1;
            end
        end
        else if (cmd.rest_upd && room)
        begin
            ent_we = 1'b1;
            ent_wa = {side_reg, price_reg, tail};
            ent_wd = {id_reg, rem_reg};
            lvl_we = 1'b1;
            lvl_wa = {side_reg, price_reg};
            lvl_wd = {head, count + CW'(1)};
            occ_we = 1'b1;
            occ_wa = {side_reg, price_word};
            occ_wd = occ_rd_reg | price_mask;
        end
    end

    // Level head/count memory
    always_ff @(posedge clk)
    begin
        if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
        if (lvl_re) lvl_rd_reg <= lvl_mem[lvl_ra];
    end

    // Resting order entries
    always_ff @(posedge clk)
    begin
        if (ent_we) ent_mem[ent_wa] <= ent_wd;
        if (ent_re) ent_rd_reg <= ent_mem[ent_ra];
    end

    // Level occupancy words
    always_ff @(posedge clk)
    begin
        if (occ_we) occ_mem[occ_wa] <= occ_wd;
        if (occ_re) occ_rd_reg <= occ_mem[occ_ra];
    end

    // Next values of order, book and result registers
    always_comb
    begin
        side_next      = side_reg;
        price_next     = price_reg;
        rem_next       = rem_reg;
        id_next        = id_reg;
        filled_next    = filled_reg;
        touches_next   = touches_reg;
        rested_next    = rested_reg;
        rejected_next  = rejected_reg;
        bbv_next       = bbv_reg;
        bbl_next       = bbl_reg;
        bav_next       = bav_reg;
        bal_next       = bal_reg;
        scan_word_next = scan_word_reg;
        clr_cnt_next   = clr_cnt_reg;

        if (cmd.clr) clr_cnt_next = clr_cnt_reg + 1'b1;

        if (stat.in_fire)
        begin
            side_next     = orders.side;
            price_next    = price_sat;
            rem_next      = orders.quantity;
            id_next       = orders.order_id;
            filled_next   = '0;
            touches_next  = '0;
            rested_next   = 1'b0;
            rejected_next = 1'b0;
        end

        if (cmd.match_upd)
        begin
            rem_next    = rem_reg - trade;
            filled_next = filled_reg + trade;
            if (touches_reg != '1) touches_next = touches_reg + 1'b1;
        end

        if (cmd.scan_init) scan_word_next = opp_word;

        // Next best level on the opposite side
        if (cmd.scan_eval)
        begin
            priority if (scan_hit)
            begin
                if (opp == SIDE_SELL)
                begin
                    bav_next = 1'b1;
                    bal_next = scan_lvl;
                end
                else
                begin
                    bbv_next = 1'b1;
                    bbl_next = scan_lvl;
                end
            end
            else if (scan_last)
            begin
                if (opp == SIDE_SELL) bav_next = 1'b0;
                else                  bbv_next = 1'b0;
            end
            else if (opp == SIDE_SELL)
            begin
                scan_word_next = scan_word_reg + 1'b1;
            end
            else
            begin
                scan_word_next = scan_word_reg - 1'b1;
            end
        end

        // Rest the remainder
        if (cmd.rest_upd)
        begin
            if (room)
            begin
                rested_next = 1'b1;
                if (side_reg == SIDE_BUY)
                begin
                    if (!bbv_reg || price_reg > bbl_reg)
                    begin
                        bbv_next = 1'b1;
                        bbl_next = price_reg;
                    end
                end
                else if (!bav_reg || price_reg < bal_reg)
                begin
                    bav_next = 1'b1;
                    bal_next = price_reg;
                end
            end
            else
            begin
                rejected_next = 1'b1;
            end
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)          out_valid_next = 1'b1;
        else if (results.ready)    out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bbv_reg       <= 1'b0;
            bbl_reg       <= '0;
            bav_reg       <= 1'b0;
            bal_reg       <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bbv_reg       <= bbv_next;
            bbl_reg       <= bbl_next;
            bav_reg       <= bav_next;
            bal_reg       <= bal_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        side_reg      <= side_next;
        price_reg     <= price_next;
        rem_reg       <= rem_next;
        id_reg        <= id_next;
        filled_reg    <= filled_next;
        touches_reg   <= touches_next;
        rested_reg    <= rested_next;
        rejected_reg  <= rejected_next;
        scan_word_reg <= scan_word_next;
        if (cmd.out_load)
        begin
            out_filled_reg   <= filled_reg;
            out_rem_reg      <= rem_reg;
            out_rested_reg   <= rested_reg;
            out_rejected_reg <= rejected_reg;
            out_fills_reg    <= touches_reg;
            out_bbv_reg      <= bbv_reg;
            out_bbp_reg      <= bbv_reg ? PRICE_W'(bbl_reg) : '0;
            out_bav_reg      <= bav_reg;
            out_bap_reg      <= bav_reg ? PRICE_W'(bal_reg) : '0;
        end
    end

    // Result channel
    assign results.valid              = out_valid_reg;
    assign results.filled_quantity    = out_filled_reg;
    assign results.remaining_quantity = out_rem_reg;
    assign results.rested             = out_rested_reg;
    assign results.rejected           = out_rejected_reg;
    assign results.fill_count         = out_fills_reg;
    assign results.best_bid_valid     = out_bbv_reg;
    assign results.best_bid_price     = out_bbp_reg;
    assign results.best_ask_valid     = out_bav_reg;
    assign results.best_ask_price     = out_bap_reg;

    // A trade step moves quantity from remainder to filled, never creating any
    `LOBM_ASSERT(a_trade_conserves, clk, rst_n, cmd.match_upd |=> (QTY_W'(filled_reg + rem_reg) == $past(QTY_W'(filled_reg + rem_reg))), "trade step lost quantity")
    // Resting orders never hold zero quantity, so each step trades something
    `LOBM_ASSERT(a_trade_progress, clk, rst_n, cmd.match_upd |=> (filled_reg != $past(filled_reg)), "trade step filled nothing")
    // A bid that rests leaves a valid best bid
    `LOBM_ASSERT(a_rest_sets_bid, clk, rst_n, (cmd.rest_upd && room && side_reg == SIDE_BUY) |=> bbv_reg, "rested bid not reflected in best bid")

endmodule

`default_nettype wire

@@ rtl/limit_order_book_matcher_core.sv @@
// Price-time priority limit order book: orders in, one summary result out.
//
// Channel orders carries opcode, side, price, quantity and order_id; channel
// results carries the per-order summary with the best bid and ask after it.
// Both use valid/ready; an item moves when both are high at a clock edge.
// After reset the block clears its level table and occupancy bits, one entry
// a cycle, and accepts no order until that pass ends.
// Orders are handled one at a time. A zero-quantity order goes straight to
// its result; a rest-only order does a level read and an update; a match
// order does a level read, an entry read and an update per fill, then a
// level read and an update when a remainder rests. A level that empties
// adds a scan of the occupancy memory, one 64-level word at a time.
// The result sits in an output register; the next order is accepted while it
// waits, but its own result is held until the receiver takes the previous one.
`default_nettype none

module limit_order_book_matcher_core import lobm_pkg::*;
#(
    parameter int PRICE_LEVELS     = PRICE_LEVELS_DEF,
    parameter int ORDERS_PER_LEVEL = ORDERS_PER_LEVEL_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,
    lobm_in_if.sink     orders,
    lobm_out_if.source  results
);

    lobm_cmd_t  cmd;
    lobm_stat_t stat;

    lobm_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    lobm_dp
    #(
        .PRICE_LEVELS     (PRICE_LEVELS),
        .ORDERS_PER_LEVEL (ORDERS_PER_LEVEL)
    )
    u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .orders  (orders),
        .results (results),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

`default_nettype wire
